// ===== sv/ssn_pkg.sv =====
// Shared types, constants and control encodings for the spectrum smoothing/normalizing block.
package ssn_pkg;

  localparam int MAX_LEN_DEF    = 1024;
  localparam int MAX_WINDOW_DEF = 255;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SMP_W      = 24;
  localparam int OUT_W      = 40;
  localparam int IDX_W      = 10;
  localparam int SPEC_LEN_W = 11;
  localparam int WIN_CFG_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_NORM_INDEX  = CFG_IDX_W'(3);

  localparam logic [1:0] NORM_NONE   = 2'd0;
  localparam logic [1:0] NORM_MINMAX = 2'd1;
  localparam logic [1:0] NORM_MEAN   = 2'd2;
  localparam logic [1:0] NORM_INDEX  = 2'd3;

  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_READ = 1'b1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic                    mode;
    logic signed [SMP_W-1:0] sample;
    logic                    last;
    logic [IDX_W-1:0]        read_index;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    in_range;
    logic [SPEC_LEN_W-1:0]   spectrum_length;
    logic                    overflowed;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RD_ISSUE, OP_OUT_LOAD, OP_SETUP,
    OP_PRE_RD, OP_PRE_ACC, OP_ADD_RD, OP_ADD_ACC, OP_SUB_RD, OP_SUB_ACC,
    OP_SM_DIV, OP_SM_WR, OP_IDX_RD, OP_IDX_CAP, OP_N_RD, OP_N_CAP,
    OP_N_PREP, OP_N_DIV, OP_N_WR, OP_DONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_SETUP, S_PRE_RD, S_PRE_ACC, S_ADD_RD, S_ADD_ACC,
    S_SUB_RD, S_SUB_ACC, S_SM_DIV, S_SM_WAIT, S_SM_WR, S_IDX_RD, S_IDX_CAP,
    S_N_RD, S_N_CAP, S_N_PREP, S_N_DIV, S_N_WAIT, S_N_WR, S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic smooth;
    logic pre_more;
    logic add_ok;
    logic sub_ok;
    logic last_elem;
    logic need_div;
    logic div_busy;
    logic out_full;
  } dp_status_t;

endpackage

// ===== sv/ssn_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module ssn_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ssn_div.sv =====
// Bit-serial restoring divider giving floor(a * 2^F / d), one quotient bit per cycle.
module ssn_div #(
  parameter int NW = 8,
  parameter int F  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   a,
  input  logic [NW-1:0]   d,
  output logic            busy,
  output logic [NW+F-1:0] q
);

  localparam int QW   = NW + F;
  localparam int CNTW = $clog2(QW + 1);

  logic [QW-1:0]   qn;
  logic [NW:0]     rem;
  logic [NW-1:0]   den;
  logic [CNTW-1:0] cnt;
  logic [NW:0]     rem_sh;
  logic [NW:0]     rem_sub;
  logic            ge;

  // shift the next numerator bit into the partial remainder
  assign rem_sh  = {rem[NW-1:0], qn[QW-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};
  assign q       = qn;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(QW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      qn  <= {a, {F{1'b0}}};
      rem <= '0;
      den <= d;
    end else if (busy) begin
      rem <= ge ? rem_sub : rem_sh;
      qn  <= {qn[QW-2:0], ge};
    end
  end

endmodule

// ===== sv/ssn_dp.sv =====
// Datapath: sample, smoothed and result memories, window sums, statistics and divider.
module ssn_dp import ssn_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int AW       = $clog2(MAX_LEN);
  localparam int LENW     = $clog2(MAX_LEN + 1);
  localparam int CW       = ((LENW > IDX_W) ? LENW : IDX_W) + 1;
  localparam int SW       = SMP_W + FRAC_BITS;
  localparam int SW1      = SW + 1;
  localparam int WINW     = SMP_W + $clog2(MAX_WINDOW + 1) + 1;
  localparam int SUMW     = SW + LENW;
  localparam int PRODW    = SW + LENW;
  localparam int DIVW     = (SUMW > WINW) ? SUMW : WINW;
  localparam int QW       = DIVW + FRAC_BITS;
  localparam int MW       = ((QW > OUT_W) ? QW : OUT_W) + 1;
  localparam int XW       = ((SW > OUT_W) ? SW : OUT_W) + 1;
  localparam int HALF_CAP = MAX_WINDOW / 2;

  // configuration registers
  logic                 smoothing_mode;
  logic [WIN_CFG_W-1:0] smoothing_window;
  logic [1:0]           normalization_mode;
  logic [IDX_W-1:0]     normalization_index;

  // spectrum bookkeeping
  logic [LENW-1:0] load_count;
  logic [LENW-1:0] processed_length;
  logic            results_ready;
  logic            drop_flag;
  logic            full;

  // processing registers
  logic                    smooth_en;
  logic [CW-1:0]           half;
  logic [LENW-1:0]         i_cnt;
  logic [LENW-1:0]         j_cnt;
  logic signed [WINW-1:0]  win_sum;
  logic signed [SMP_W-1:0] raw_smp;
  logic signed [SW-1:0]    min_v;
  logic signed [SW-1:0]    max_v;
  logic signed [SW-1:0]    dv;
  logic signed [SW-1:0]    cur_v;
  logic signed [SUMW-1:0]  tot_sum;
  logic                    mode3_ok;
  logic [DIVW-1:0]         num_a;
  logic [DIVW-1:0]         den_d;
  logic                    neg_q;
  logic                    rd_ok;
  result_t                 out_q;
  logic                    out_full;

  // derived values
  logic [CW-1:0]           i_ext, j_ext, n_ext, add_idx, sub_idx, lo, hi, win_cnt;
  logic [CW-1:0]           hw_raw;
  logic [WINW-1:0]         win_mag;
  logic [SW-1:0]           v_mag, dv_mag;
  logic [SUMW-1:0]         tot_mag;
  logic [PRODW-1:0]        prod;
  logic [SW1-1:0]          diff_v, range_v;
  logic signed [SW-1:0]    sm_val;
  logic signed [OUT_W-1:0] norm_val;
  logic                    need_div;

  // memory ports
  logic [AW-1:0]           smp_raddr, sm_raddr;
  logic                    smp_re, sm_re;
  logic [SMP_W-1:0]        smp_rdata;
  logic [SW-1:0]           sm_rdata;
  logic [OUT_W-1:0]        res_rdata;
  logic signed [SMP_W-1:0] smp_rd;
  logic signed [SW-1:0]    sm_rd;

  // divider ports
  logic            div_start, div_busy;
  logic [DIVW-1:0] div_a, div_d;
  logic [QW-1:0]   div_q;

  function automatic logic signed [OUT_W-1:0] sres(input logic [QW-1:0] mag, input logic neg);
    logic [MW-1:0] me;
    logic [MW-1:0] lim;
    me  = MW'(mag);
    lim = MW'(OUT_MAX);
    if (me > lim) begin
      return neg ? OUT_MIN : OUT_MAX;
    end
    return neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [XW-1:0] xe;
    xe = XW'(x);
    if (xe > XW'(OUT_MAX)) begin
      return OUT_MAX;
    end
    if (xe < XW'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return OUT_W'(xe);
  endfunction

  assign smp_rd = smp_rdata;
  assign sm_rd  = sm_rdata;
  assign full   = load_count == LENW'(MAX_LEN);

  // window geometry for the current element
  assign i_ext   = CW'(i_cnt);
  assign j_ext   = CW'(j_cnt);
  assign n_ext   = CW'(load_count);
  assign add_idx = i_ext + half;
  assign sub_idx = i_ext - half - CW'(1);
  assign lo      = (i_ext < half) ? '0 : i_ext - half;
  assign hi      = (add_idx > n_ext - CW'(1)) ? n_ext - CW'(1) : add_idx;
  assign win_cnt = hi - lo + CW'(1);
  assign hw_raw  = CW'(smoothing_window >> 1);

  // magnitudes and normalization operands
  assign win_mag = win_sum[WINW-1] ? -win_sum : win_sum;
  assign v_mag   = cur_v[SW-1] ? -cur_v : cur_v;
  assign dv_mag  = dv[SW-1] ? -dv : dv;
  assign tot_mag = tot_sum[SUMW-1] ? -tot_sum : tot_sum;
  assign prod    = PRODW'(v_mag) * PRODW'(load_count);
  assign diff_v  = SW1'(cur_v) - SW1'(min_v);
  assign range_v = SW1'(max_v) - SW1'(min_v);

  always_comb begin
    case (normalization_mode)
      NORM_MINMAX: need_div = range_v != '0;
      NORM_MEAN:   need_div = tot_sum != '0;
      NORM_INDEX:  need_div = mode3_ok;
      default:     need_div = 1'b0;
    endcase
  end

  // smoothed value of the current element
  always_comb begin
    if (smooth_en) begin
      sm_val = SW'(sres(div_q, win_sum[WINW-1]));
    end else begin
      sm_val = SW'(raw_smp) <<< FRAC_BITS;
    end
  end

  // normalized value of the current element
  always_comb begin
    if (need_div) begin
      norm_val = sres(div_q, neg_q);
    end else if (normalization_mode == NORM_MINMAX) begin
      norm_val = '0;
    end else begin
      norm_val = sat(cur_v);
    end
  end

  // status toward the controller; out_full means the result register stays taken
  always_comb begin
    status.smooth    = smooth_en;
    status.pre_more  = smooth_en && (j_ext < half) && (j_ext < n_ext);
    status.add_ok    = smooth_en && (add_idx < n_ext);
    status.sub_ok    = smooth_en && (i_ext > half);
    status.last_elem = (i_ext + CW'(1)) == n_ext;
    status.need_div  = need_div;
    status.div_busy  = div_busy;
    status.out_full  = out_full && result_stall;
  end

  // memory address selection
  always_comb begin
    smp_re    = 1'b0;
    smp_raddr = AW'(i_cnt);
    sm_re     = 1'b0;
    sm_raddr  = AW'(i_cnt);
    case (cmd.op)
      OP_PRE_RD: begin
        smp_re    = 1'b1;
        smp_raddr = AW'(j_cnt);
      end
      OP_ADD_RD: begin
        smp_re    = 1'b1;
        smp_raddr = smooth_en ? AW'(add_idx) : AW'(i_cnt);
      end
      OP_SUB_RD: begin
        smp_re    = 1'b1;
        smp_raddr = AW'(sub_idx);
      end
      OP_IDX_RD: begin
        sm_re    = 1'b1;
        sm_raddr = AW'(normalization_index);
      end
      OP_N_RD: begin
        sm_re = 1'b1;
      end
      default: begin
        smp_re = 1'b0;
      end
    endcase
  end

  ssn_ram #(.W(SMP_W), .DEPTH(MAX_LEN)) u_sample_mem (
    .clk   (clk),
    .we    (cmd.op == OP_LOAD && !full),
    .waddr (AW'(load_count)),
    .wdata (item.sample),
    .re    (smp_re),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  ssn_ram #(.W(SW), .DEPTH(MAX_LEN)) u_smooth_mem (
    .clk   (clk),
    .we    (cmd.op == OP_SM_WR),
    .waddr (AW'(i_cnt)),
    .wdata (sm_val),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  ssn_ram #(.W(OUT_W), .DEPTH(MAX_LEN)) u_result_mem (
    .clk   (clk),
    .we    (cmd.op == OP_N_WR),
    .waddr (AW'(i_cnt)),
    .wdata (norm_val),
    .re    (cmd.op == OP_RD_ISSUE),
    .raddr (AW'(item.read_index)),
    .rdata (res_rdata)
  );

  // divider operand selection
  assign div_start = (cmd.op == OP_SM_DIV) || (cmd.op == OP_N_DIV);
  assign div_a     = (cmd.op == OP_SM_DIV) ? DIVW'(win_mag) : num_a;
  assign div_d     = (cmd.op == OP_SM_DIV) ? DIVW'(win_cnt) : den_d;

  ssn_div #(.NW(DIVW), .F(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .d     (div_d),
    .busy  (div_busy),
    .q     (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_mode      <= 1'b0;
      smoothing_window    <= '0;
      normalization_mode  <= NORM_NONE;
      normalization_index <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTH_MODE: smoothing_mode      <= cfg_data[0];
        REG_SMOOTH_WIN:  smoothing_window    <= cfg_data[WIN_CFG_W-1:0];
        REG_NORM_MODE:   normalization_mode  <= cfg_data[1:0];
        REG_NORM_INDEX:  normalization_index <= cfg_data[IDX_W-1:0];
        default:         smoothing_mode      <= smoothing_mode;
      endcase
    end
  end

  // spectrum bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count       <= '0;
      processed_length <= '0;
      results_ready    <= 1'b0;
      drop_flag        <= 1'b0;
      out_full         <= 1'b0;
      smooth_en        <= 1'b0;
    end else begin
      // fill on a read, drop after the transfer
      if (cmd.op == OP_OUT_LOAD) begin
        out_full <= 1'b1;
      end else if (!result_stall) begin
        out_full <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (full) begin
            drop_flag <= 1'b1;
          end else begin
            load_count <= load_count + LENW'(1);
            if (load_count == '0) begin
              drop_flag <= 1'b0;
            end
          end
        end
        OP_SETUP: begin
          smooth_en <= smoothing_mode && (smoothing_window > WIN_CFG_W'(1))
                       && (load_count >= LENW'(2));
        end
        OP_DONE: begin
          processed_length <= load_count;
          results_ready    <= 1'b1;
          load_count       <= '0;
        end
        default: ;
      endcase
    end
  end

  // processing payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RD_ISSUE: begin
        rd_ok <= results_ready && (CW'(item.read_index) < CW'(processed_length))
                 && (CW'(item.read_index) < CW'(MAX_LEN));
      end
      OP_OUT_LOAD: begin
        out_q.value           <= rd_ok ? res_rdata : '0;
        out_q.in_range        <= rd_ok;
        out_q.spectrum_length <= SPEC_LEN_W'(processed_length);
        out_q.overflowed      <= drop_flag;
      end
      OP_SETUP: begin
        half    <= (hw_raw > CW'(HALF_CAP)) ? CW'(HALF_CAP) : hw_raw;
        i_cnt   <= '0;
        j_cnt   <= '0;
        win_sum <= '0;
      end
      OP_PRE_ACC: begin
        win_sum <= win_sum + WINW'(smp_rd);
        j_cnt   <= j_cnt + LENW'(1);
      end
      OP_ADD_ACC: begin
        if (smooth_en) begin
          win_sum <= win_sum + WINW'(smp_rd);
        end else begin
          raw_smp <= smp_rd;
        end
      end
      OP_SUB_ACC: win_sum <= win_sum - WINW'(smp_rd);
      OP_SM_WR: begin
        if (i_cnt == '0) begin
          min_v   <= sm_val;
          max_v   <= sm_val;
          tot_sum <= SUMW'(sm_val);
        end else begin
          if (sm_val < min_v) begin
            min_v <= sm_val;
          end
          if (sm_val > max_v) begin
            max_v <= sm_val;
          end
          tot_sum <= tot_sum + SUMW'(sm_val);
        end
        i_cnt <= i_cnt + LENW'(1);
      end
      OP_IDX_RD: i_cnt <= '0;
      OP_IDX_CAP: begin
        dv       <= sm_rd;
        mode3_ok <= (normalization_mode == NORM_INDEX)
                    && (CW'(normalization_index) < n_ext) && (sm_rd != '0);
      end
      OP_N_CAP: cur_v <= sm_rd;
      OP_N_PREP: begin
        case (normalization_mode)
          NORM_MINMAX: begin
            num_a <= DIVW'(diff_v);
            den_d <= DIVW'(range_v);
            neg_q <= 1'b0;
          end
          NORM_MEAN: begin
            num_a <= DIVW'(prod);
            den_d <= DIVW'(tot_mag);
            neg_q <= cur_v[SW-1] ^ tot_sum[SUMW-1];
          end
          default: begin
            num_a <= DIVW'(v_mag);
            den_d <= DIVW'(dv_mag);
            neg_q <= cur_v[SW-1] ^ dv[SW-1];
          end
        endcase
      end
      OP_N_WR: i_cnt <= i_cnt + LENW'(1);
      default: rd_ok <= rd_ok;
    endcase
  end

  assign result_valid = out_full;
  assign result       = out_q;

endmodule

// ===== sv/ssn_ctrl.sv =====
// Controller: sequences load, read and the smoothing and normalization passes.
module ssn_ctrl import ssn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state;
  state_t state_next;
  logic   accept;

  // take items only when idle
  assign item_stall = state != S_IDLE;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.mode == ITEM_READ) begin
            state_next = S_RD_WAIT;
          end else if (item.last) begin
            state_next = S_SETUP;
          end
        end
      end
      // hold the read until the result register frees
      S_RD_WAIT:  state_next = status.out_full ? S_RD_WAIT : S_IDLE;
      S_SETUP:    state_next = S_PRE_RD;
      S_PRE_RD:   state_next = status.pre_more ? S_PRE_ACC : S_ADD_RD;
      S_PRE_ACC:  state_next = S_PRE_RD;
      S_ADD_RD:   state_next = (!status.smooth || status.add_ok) ? S_ADD_ACC : S_SUB_RD;
      S_ADD_ACC:  state_next = status.smooth ? S_SUB_RD : S_SM_WR;
      S_SUB_RD:   state_next = status.sub_ok ? S_SUB_ACC : S_SM_DIV;
      S_SUB_ACC:  state_next = S_SM_DIV;
      S_SM_DIV:   state_next = S_SM_WAIT;
      S_SM_WAIT:  state_next = status.div_busy ? S_SM_WAIT : S_SM_WR;
      S_SM_WR:    state_next = status.last_elem ? S_IDX_RD : S_ADD_RD;
      S_IDX_RD:   state_next = S_IDX_CAP;
      S_IDX_CAP:  state_next = S_N_RD;
      S_N_RD:     state_next = S_N_CAP;
      S_N_CAP:    state_next = S_N_PREP;
      S_N_PREP:   state_next = status.need_div ? S_N_DIV : S_N_WR;
      S_N_DIV:    state_next = S_N_WAIT;
      S_N_WAIT:   state_next = status.div_busy ? S_N_WAIT : S_N_WR;
      S_N_WR:     state_next = status.last_elem ? S_DONE : S_N_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op = (item.mode == ITEM_READ) ? OP_RD_ISSUE : OP_LOAD;
        end
      end
      S_RD_WAIT:  cmd.op = status.out_full ? OP_NONE : OP_OUT_LOAD;
      S_SETUP:    cmd.op = OP_SETUP;
      S_PRE_RD:   cmd.op = status.pre_more ? OP_PRE_RD : OP_NONE;
      S_PRE_ACC:  cmd.op = OP_PRE_ACC;
      S_ADD_RD:   cmd.op = (!status.smooth || status.add_ok) ? OP_ADD_RD : OP_NONE;
      S_ADD_ACC:  cmd.op = OP_ADD_ACC;
      S_SUB_RD:   cmd.op = status.sub_ok ? OP_SUB_RD : OP_NONE;
      S_SUB_ACC:  cmd.op = OP_SUB_ACC;
      S_SM_DIV:   cmd.op = OP_SM_DIV;
      S_SM_WR:    cmd.op = OP_SM_WR;
      S_IDX_RD:   cmd.op = OP_IDX_RD;
      S_IDX_CAP:  cmd.op = OP_IDX_CAP;
      S_N_RD:     cmd.op = OP_N_RD;
      S_N_CAP:    cmd.op = OP_N_CAP;
      S_N_PREP:   cmd.op = OP_N_PREP;
      S_N_DIV:    cmd.op = OP_N_DIV;
      S_N_WR:     cmd.op = OP_N_WR;
      S_DONE:     cmd.op = OP_DONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== sv/spectrum_smooth_normalize.sv =====
// Top level: spectrum loader with moving-average smoothing and normalization.
//
// Items arrive on the item channel (valid/stall). A load item (mode 0) writes
// one sample; samples past MAX_LEN are dropped and flagged. A load item with
// last set starts processing: a smoothing pass then a normalization pass
// over the stored spectrum. Each element costs up to one serial division per
// pass, and none in modes without a division. The divider and the single read
// port of each memory set the processing time. A read item (mode 1) returns
// one transfer on the result channel: the result memory is read, then the
// output register is loaded, later if the previous result still waits.
// Load items return nothing. item_stall stays high while processing and while
// a read waits for the result register; a waiting result does not block loads.
// The result register holds its value until the transfer.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, which the block itself does not enforce.
// Reset clears the configuration, the counts and the ready, overflow, output
// and smoothing flags; memories are not cleared, and data read from entries
// that were never written is never used.
module spectrum_smooth_normalize import ssn_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ssn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  ssn_dp #(
    .MAX_LEN    (MAX_LEN),
    .MAX_WINDOW (MAX_WINDOW),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

  // a stalled result holds steady
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // a read transfer yields a result once the result memory read and the output register load are done
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.mode == ITEM_READ) |=> ##1 result_valid)
    else $error("read result missing");

  // a load transfer never raises a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.mode == ITEM_LOAD) |=> !$rose(result_valid))
    else $error("load produced a result");

  // an in-range result implies a nonempty spectrum
  a_range_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.in_range) |-> (result.spectrum_length != '0))
    else $error("in-range result with empty spectrum");

endmodule

// ===== tb/spectrum_smooth_normalize_test.sv =====
// Testbench for spectrum_smooth_normalize: random spectra checked against a built-in predictor.
`timescale 1ns / 1ps

module spectrum_smooth_normalize_test;
  import ssn_pkg::*;

  localparam int SPEC_CAP      = 1024;
  localparam int HALF_CAP      = 127;
  localparam int FRAC          = 16;
  localparam int ITEM_TARGET   = 1180;
  localparam int STUCK_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;
  localparam bit [63:0] MAG_LIMIT = 64'd1 << 40;
  localparam longint VAL_MAX = 64'sd549755813887;
  localparam longint VAL_MIN = -64'sd549755813888;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;

  spectrum_smooth_normalize u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // Shadow configuration and spectrum state
  logic         sh_smooth;
  logic [7:0]   sh_window;
  logic [1:0]   sh_norm;
  logic [9:0]   sh_norm_idx;
  longint       samples [SPEC_CAP];
  longint       smoothed [SPEC_CAP];
  longint       processed [SPEC_CAP];
  int           load_cnt;
  int           proc_len;
  bit           have_results;
  bit           dropped;

  item_t        pending_items [$];
  result_t      expected_results [$];
  int           mismatches;
  int           idle_cycles;
  bit           item_took;
  bit           quiet;
  int           items_sent;
  int           last_len;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit [63:0] mag_of(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // floor(a * 2^FRAC / d), capped at 2^40
  function automatic bit [63:0] frac_div(bit [63:0] a, bit [63:0] d);
    bit [63:0] q, r;
    q = a / d;
    r = a % d;
    if (q >= MAG_LIMIT) return MAG_LIMIT;
    for (int i = 0; i < FRAC; i++) begin
      q = q << 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q = q | 64'd1;
      end else begin
        r = r << 1;
      end
      if (q >= MAG_LIMIT) return MAG_LIMIT;
    end
    return q;
  endfunction

  function automatic longint signed_sat(bit [63:0] m, bit neg);
    if (neg) return (m > 64'(VAL_MAX)) ? VAL_MIN : -longint'(m);
    return (m > 64'(VAL_MAX)) ? VAL_MAX : longint'(m);
  endfunction

  function automatic longint clamp_out(longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  // Smooth then normalize the loaded spectrum
  task automatic process_spectrum();
    int n, w, half, lo, hi;
    bit do_smooth;
    longint s, mn, mx, dv;
    bit [63:0] d;
    n = load_cnt;
    w = sh_window;
    do_smooth = sh_smooth && w > 1 && n >= 2;
    if (w % 2 == 0) w++;
    half = w / 2;
    if (half > HALF_CAP) half = HALF_CAP;
    for (int i = 0; i < n; i++) begin
      if (do_smooth) begin
        lo = i < half ? 0 : i - half;
        hi = i + half > n - 1 ? n - 1 : i + half;
        s = 0;
        for (int j = lo; j <= hi; j++) s += samples[j];
        smoothed[i] = signed_sat(frac_div(mag_of(s), 64'(hi - lo + 1)), s < 0);
      end else begin
        smoothed[i] = samples[i] * (64'sd1 << FRAC);
      end
    end
    if (sh_norm == NORM_MINMAX) begin
      mn = smoothed[0];
      mx = smoothed[0];
      for (int i = 1; i < n; i++) begin
        if (smoothed[i] < mn) mn = smoothed[i];
        if (smoothed[i] > mx) mx = smoothed[i];
      end
      d = 64'(mx) - 64'(mn);
      for (int i = 0; i < n; i++)
        processed[i] = (d == 0) ? 0 :
            signed_sat(frac_div(64'(smoothed[i]) - 64'(mn), d), 1'b0);
    end else if (sh_norm == NORM_MEAN) begin
      s = 0;
      for (int i = 0; i < n; i++) s += smoothed[i];
      for (int i = 0; i < n; i++)
        processed[i] = (s == 0) ? clamp_out(smoothed[i]) :
            signed_sat(frac_div(mag_of(smoothed[i]) * 64'(n), mag_of(s)),
                       (smoothed[i] < 0) != (s < 0));
    end else if (sh_norm == NORM_INDEX && int'(sh_norm_idx) < n &&
                 smoothed[sh_norm_idx] != 0) begin
      dv = smoothed[sh_norm_idx];
      for (int i = 0; i < n; i++)
        processed[i] = signed_sat(frac_div(mag_of(smoothed[i]), mag_of(dv)),
                                  (smoothed[i] < 0) != (dv < 0));
    end else begin
      for (int i = 0; i < n; i++) processed[i] = clamp_out(smoothed[i]);
    end
    proc_len = n;
    have_results = 1'b1;
    load_cnt = 0;
  endtask

  // Apply one accepted item to the shadow state
  task automatic apply_item(item_t it);
    result_t r;
    bit ok;
    if (it.mode == ITEM_LOAD) begin
      if (load_cnt == 0) dropped = 1'b0;
      if (load_cnt < SPEC_CAP) begin
        samples[load_cnt] = longint'(it.sample);
        load_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (it.last) process_spectrum();
    end else begin
      ok = have_results && int'(it.read_index) < proc_len;
      r.value = ok ? processed[it.read_index][OUT_W-1:0] : '0;
      r.in_range = ok;
      r.spectrum_length = SPEC_LEN_W'(proc_len);
      r.overflowed = dropped;
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  // Sample outputs, predict, compare
  always @(posedge clk) begin
    result_t want;
    item_took = item_valid && !item_stall;
    if (!rst) begin
      if (item_took) apply_item(item);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result transfer: %p", result);
        end else begin
          want = expected_results.pop_front();
          if (result.value !== want.value || result.in_range !== want.in_range ||
              result.spectrum_length !== want.spectrum_length ||
              result.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result mismatch: expected %p, got %p", want, result);
          end
        end
      end
    end
  end

  // Drive items and result stall at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      result_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 33);
      if (!item_valid || item_took) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 33)) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Hang detection
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STUCK_LIMIT) begin
        $display("spectrum_smooth_normalize_test: done, errors");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      REG_SMOOTH_MODE: sh_smooth = val[0];
      REG_SMOOTH_WIN:  sh_window = val[7:0];
      REG_NORM_MODE:   sh_norm = val[1:0];
      REG_NORM_INDEX:  sh_norm_idx = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int sm, int win, int nm, int nidx);
    cfg_write(REG_SMOOTH_MODE, sm);
    cfg_write(REG_SMOOTH_WIN, win);
    cfg_write(REG_NORM_MODE, nm);
    cfg_write(REG_NORM_INDEX, nidx);
  endtask

  // Hold until every item is sent, every result is back and processing is over
  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    while (item_stall) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_load(int smp, bit lst);
    item_t it;
    it.mode = ITEM_LOAD;
    it.sample = SMP_W'(smp);
    it.last = lst;
    it.read_index = IDX_W'($urandom);
    pending_items.insert(pending_items.size(), it);
    items_sent++;
  endtask

  task automatic push_read(int idx);
    item_t it;
    it.mode = ITEM_READ;
    it.sample = SMP_W'($urandom);
    it.last = 1'($urandom_range(0, 1));
    it.read_index = IDX_W'(idx);
    pending_items.insert(pending_items.size(), it);
    items_sent++;
  endtask

  function automatic int pick_sample(int flavor, int pos, int base);
    case (flavor)
      0: return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
      1: return int'($urandom_range(0, 100)) - 50;
      2: return base;
      3: return (pos % 2 == 0) ? 8388607 : -8388608;
      4: return (pos % 2 == 0) ? base : -base;
      default: return 0;
    endcase
  endfunction

  function automatic int pick_index();
    case ($urandom_range(0, 5))
      0: return 1023;
      1: return $urandom_range(0, 1023);
      default: return $urandom_range(0, last_len + 1);
    endcase
  endfunction

  // One spectrum with reads sprinkled in, then a burst of reads
  task automatic send_spectrum(int len);
    int flavor, base;
    flavor = $urandom_range(0, 5);
    base = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
    if (flavor == 4 && base == -8388608) base = 5;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 15) push_read(pick_index());
      push_load(pick_sample(flavor, i, base), i == len - 1);
    end
    last_len = len;
    repeat ($urandom_range(2, 8)) push_read(pick_index());
  endtask

  initial begin
    int win, nidx, len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    item_took = 1'b0;
    quiet = 1'b0;
    items_sent = 0;
    last_len = 0;
    load_cnt = 0;
    proc_len = 0;
    have_results = 1'b0;
    dropped = 1'b0;
    sh_smooth = 1'b0;
    sh_window = '0;
    sh_norm = NORM_NONE;
    sh_norm_idx = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reads before any spectrum, extremes, single sample
    set_config(0, 0, NORM_NONE, 0);
    push_read(0);
    push_read(1023);
    push_load(-8388608, 1'b0);
    push_load(8388607, 1'b0);
    push_load(0, 1'b0);
    push_load(-1, 1'b0);
    push_load(1, 1'b1);
    for (int i = 0; i < 6; i++) push_read(i);
    push_read(1023);
    push_load(-77, 1'b1);
    push_read(0);
    push_read(1);
    drain();

    // Full-range smoothing with overflow past capacity, no stalls
    quiet = 1'b1;
    set_config(1, 255, NORM_MEAN, 1023);
    for (int i = 0; i < SPEC_CAP + 6; i++)
      push_load(pick_sample(i < 300 ? 3 : 0, i, 0), i == SPEC_CAP + 5);
    push_read(0);
    push_read(1023);
    push_read($urandom_range(0, 1023));
    push_load(12, 1'b0);
    push_read(1023);
    push_load(-12, 1'b1);
    push_read(1);
    push_read(2);
    drain();
    quiet = 1'b0;

    // Random phases over varied settings
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: win = 255;
        1: win = 254;
        2: win = $urandom_range(0, 2);
        default: win = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 4))
        0: nidx = 1023;
        default: nidx = $urandom_range(0, 10);
      endcase
      set_config($urandom_range(0, 1), win, $urandom_range(0, 3), nidx);
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
        send_spectrum(len);
      end
      drain();
    end

    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("spectrum_smooth_normalize_test: done, clean");
    end else begin
      $display("spectrum_smooth_normalize_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ssn_pkg.sv
sv/ssn_ram.sv
sv/ssn_div.sv
sv/ssn_dp.sv
sv/ssn_ctrl.sv
sv/spectrum_smooth_normalize.sv
tb/spectrum_smooth_normalize_test.sv
